### rtl/core/mhpq_pkg.sv
package mhpq_pkg;

    localparam int CAPACITY   = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CHILD_W    = ADDR_W + 2;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [VALUE_W-1:0]    t_value;
    typedef logic [ADDR_W-1:0]            t_addr;
    typedef logic [CNT_W-1:0]             t_count;
    typedef logic [CHILD_W-1:0]           t_child;
    typedef logic [STATUS_W-1:0]          t_status;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHECK,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_CHECK,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_LAST,
        RD_PARENT,
        RD_LEFT,
        RD_RIGHT
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_VAL,
        WR_RDATA,
        WR_CHILD
    } t_wr_sel;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_PARENT,
        IDX_PICK
    } t_idx_sel;

    typedef struct packed {
        logic     ld_ins;
        logic     ld_rm;
        logic     ld_full;
        logic     ld_empty;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_sel  wr_sel;
        t_idx_sel idx_sel;
        logic     ld_val;
        logic     ld_left;
        logic     use_right;
        logic     ld_out;
    } t_dp_cmd;

    typedef struct packed {
        logic count_full;
        logic count_zero;
        logic idx_zero;
        logic parent_lt;
        logic left_out;
        logic right_in;
        logic child_ge;
    } t_dp_stat;

endpackage

### rtl/core/mhpq_ram.sv
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/mhpq_dp.sv
module mhpq_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mhpq_pkg::t_value               i_value,
    input  mhpq_pkg::t_dp_cmd              i_cmd,
    output mhpq_pkg::t_dp_stat             o_stat,
    output mhpq_pkg::t_status              o_status,
    output logic [mhpq_pkg::VALUE_W-1:0]   o_removed_value,
    output logic [mhpq_pkg::VALUE_W-1:0]   o_top_value,
    output logic [mhpq_pkg::CNT_W-1:0]     o_entry_count,
    output logic                           o_heap_empty
);

    mhpq_pkg::t_count  r_count;
    mhpq_pkg::t_addr   r_idx;
    mhpq_pkg::t_data   r_val;
    mhpq_pkg::t_data   r_cval;
    mhpq_pkg::t_addr   r_pick;
    mhpq_pkg::t_data   r_top;
    mhpq_pkg::t_status r_status;
    mhpq_pkg::t_value  r_removed;

    mhpq_pkg::t_status r_out_status;
    mhpq_pkg::t_value  r_out_removed;
    mhpq_pkg::t_value  r_out_top;
    mhpq_pkg::t_count  r_out_count;
    logic              r_out_empty;

    logic [mhpq_pkg::DATA_WIDTH-1:0] ram_rd_data;
    mhpq_pkg::t_data   ram_q;
    mhpq_pkg::t_addr   rd_addr;
    mhpq_pkg::t_data   wr_data;
    mhpq_pkg::t_addr   parent;
    mhpq_pkg::t_child  child_left;
    mhpq_pkg::t_child  child_right;
    mhpq_pkg::t_child  count_ext;
    mhpq_pkg::t_data   chosen_val;
    mhpq_pkg::t_addr   chosen_idx;

    assign ram_q       = ram_rd_data;
    assign parent      = (r_idx - mhpq_pkg::t_addr'(1)) >> 1;
    assign child_left  = (mhpq_pkg::t_child'(r_idx) << 1) + mhpq_pkg::t_child'(1);
    assign child_right = child_left + mhpq_pkg::t_child'(1);
    assign count_ext   = mhpq_pkg::t_child'(r_count);

    always_comb begin
        if (i_cmd.use_right && (r_cval > ram_q)) begin
            chosen_val = r_cval;
            chosen_idx = r_pick;
        end else if (i_cmd.use_right) begin
            chosen_val = ram_q;
            chosen_idx = mhpq_pkg::t_addr'(child_right);
        end else begin
            chosen_val = ram_q;
            chosen_idx = mhpq_pkg::t_addr'(child_left);
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            mhpq_pkg::RD_LAST:   rd_addr = mhpq_pkg::t_addr'(r_count - mhpq_pkg::t_count'(1));
            mhpq_pkg::RD_PARENT: rd_addr = parent;
            mhpq_pkg::RD_LEFT:   rd_addr = mhpq_pkg::t_addr'(child_left);
            mhpq_pkg::RD_RIGHT:  rd_addr = mhpq_pkg::t_addr'(child_right);
            default:             rd_addr = parent;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_sel)
            mhpq_pkg::WR_VAL:   wr_data = r_val;
            mhpq_pkg::WR_RDATA: wr_data = ram_q;
            mhpq_pkg::WR_CHILD: wr_data = chosen_val;
            default:            wr_data = r_val;
        endcase
    end

    mhpq_ram #(
        .WIDTH (mhpq_pkg::DATA_WIDTH),
        .DEPTH (mhpq_pkg::CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_stat.count_full = (r_count == mhpq_pkg::t_count'(mhpq_pkg::CAPACITY));
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.idx_zero   = (r_idx == '0);
    assign o_stat.parent_lt  = (ram_q < r_val);
    assign o_stat.left_out   = (child_left >= count_ext);
    assign o_stat.right_in   = (child_right < count_ext);
    assign o_stat.child_ge   = !(chosen_val < r_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ld_ins) begin
            r_count <= r_count + mhpq_pkg::t_count'(1);
        end else if (i_cmd.ld_rm) begin
            r_count <= r_count - mhpq_pkg::t_count'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_ins) begin
            r_val <= mhpq_pkg::DATA_WIDTH'(i_value);
            r_idx <= mhpq_pkg::t_addr'(r_count);
        end else if (i_cmd.ld_rm) begin
            r_idx <= '0;
        end else if (i_cmd.idx_sel == mhpq_pkg::IDX_PARENT) begin
            r_idx <= parent;
        end else if (i_cmd.idx_sel == mhpq_pkg::IDX_PICK) begin
            r_idx <= chosen_idx;
        end
        if (i_cmd.ld_val) begin
            r_val <= ram_q;
        end
        if (i_cmd.ld_left) begin
            r_cval <= ram_q;
            r_pick <= mhpq_pkg::t_addr'(child_left);
        end
        if (i_cmd.wr_en && (r_idx == '0)) begin
            r_top <= wr_data;
        end
        if (i_cmd.ld_ins) begin
            r_status  <= mhpq_pkg::STATUS_OK;
            r_removed <= '0;
        end else if (i_cmd.ld_rm) begin
            r_status  <= mhpq_pkg::STATUS_OK;
            r_removed <= mhpq_pkg::VALUE_W'(r_top);
        end else if (i_cmd.ld_full) begin
            r_status  <= mhpq_pkg::STATUS_FULL;
            r_removed <= '0;
        end else if (i_cmd.ld_empty) begin
            r_status  <= mhpq_pkg::STATUS_EMPTY;
            r_removed <= '0;
        end
        if (i_cmd.ld_out) begin
            r_out_status  <= r_status;
            r_out_removed <= r_removed;
            r_out_top     <= (r_count == '0) ? '0 : mhpq_pkg::VALUE_W'(r_top);
            r_out_count   <= r_count;
            r_out_empty   <= (r_count == '0);
        end
    end

    assign o_status        = r_out_status;
    assign o_removed_value = r_out_removed;
    assign o_top_value     = r_out_top;
    assign o_entry_count   = r_out_count;
    assign o_heap_empty    = r_out_empty;

endmodule

### rtl/core/mhpq_ctrl.sv
module mhpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_kind,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    input  mhpq_pkg::t_dp_stat i_stat,
    output mhpq_pkg::t_dp_cmd  o_cmd
);

    mhpq_pkg::t_state r_state;
    mhpq_pkg::t_state n_state;
    logic             r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhpq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            mhpq_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && (i_kind == mhpq_pkg::KIND_REMOVE)) begin
                    if (i_stat.count_zero) begin
                        o_cmd.ld_empty = 1'b1;
                        n_state        = mhpq_pkg::S_DONE;
                    end else begin
                        o_cmd.ld_rm  = 1'b1;
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = mhpq_pkg::RD_LAST;
                        n_state      = mhpq_pkg::S_DN_LOAD;
                    end
                end else if (i_valid) begin
                    if (i_stat.count_full) begin
                        o_cmd.ld_full = 1'b1;
                        n_state       = mhpq_pkg::S_DONE;
                    end else begin
                        o_cmd.ld_ins = 1'b1;
                        n_state      = mhpq_pkg::S_UP_CHECK;
                    end
                end
            end
            mhpq_pkg::S_UP_CHECK: begin
                if (i_stat.idx_zero) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = mhpq_pkg::WR_VAL;
                    n_state      = mhpq_pkg::S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = mhpq_pkg::RD_PARENT;
                    n_state      = mhpq_pkg::S_UP_CMP;
                end
            end
            mhpq_pkg::S_UP_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.parent_lt) begin
                    o_cmd.wr_sel  = mhpq_pkg::WR_RDATA;
                    o_cmd.idx_sel = mhpq_pkg::IDX_PARENT;
                    n_state       = mhpq_pkg::S_UP_CHECK;
                end else begin
                    o_cmd.wr_sel = mhpq_pkg::WR_VAL;
                    n_state      = mhpq_pkg::S_DONE;
                end
            end
            mhpq_pkg::S_DN_LOAD: begin
                o_cmd.ld_val = 1'b1;
                n_state      = mhpq_pkg::S_DN_CHECK;
            end
            mhpq_pkg::S_DN_CHECK: begin
                if (i_stat.left_out) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = mhpq_pkg::WR_VAL;
                    n_state      = mhpq_pkg::S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = mhpq_pkg::RD_LEFT;
                    n_state      = mhpq_pkg::S_DN_LEFT;
                end
            end
            mhpq_pkg::S_DN_LEFT: begin
                if (i_stat.right_in) begin
                    o_cmd.ld_left = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = mhpq_pkg::RD_RIGHT;
                    n_state       = mhpq_pkg::S_DN_RIGHT;
                end else if (i_stat.child_ge) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = mhpq_pkg::WR_CHILD;
                    o_cmd.idx_sel = mhpq_pkg::IDX_PICK;
                    n_state       = mhpq_pkg::S_DN_CHECK;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = mhpq_pkg::WR_VAL;
                    n_state      = mhpq_pkg::S_DONE;
                end
            end
            mhpq_pkg::S_DN_RIGHT: begin
                o_cmd.use_right = 1'b1;
                o_cmd.wr_en     = 1'b1;
                if (i_stat.child_ge) begin
                    o_cmd.wr_sel  = mhpq_pkg::WR_CHILD;
                    o_cmd.idx_sel = mhpq_pkg::IDX_PICK;
                    n_state       = mhpq_pkg::S_DN_CHECK;
                end else begin
                    o_cmd.wr_sel = mhpq_pkg::WR_VAL;
                    n_state      = mhpq_pkg::S_DONE;
                end
            end
            mhpq_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = mhpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mhpq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/max_heap_priority_queue.sv
// An insert climbs the new word up level by level; a rejected word goes straight to the result.
// A remove moves the last word to the root and sinks it level by level.
// The heap store has a single read port; one word is in work at a time.
// The result is registered and held on the output until it is taken; a new result waits until then.
// Reset is synchronous and clears the count, the controller and the output valid.
// Store contents are not cleared; no entry at or above the count is ever read.
module max_heap_priority_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_kind,
    input  logic [mhpq_pkg::VALUE_W-1:0]   i_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [mhpq_pkg::STATUS_W-1:0]  o_status,
    output logic [mhpq_pkg::VALUE_W-1:0]   o_removed_value,
    output logic [mhpq_pkg::VALUE_W-1:0]   o_top_value,
    output logic [mhpq_pkg::CNT_W-1:0]     o_entry_count,
    output logic                           o_heap_empty
);

    mhpq_pkg::t_dp_cmd  cmd;
    mhpq_pkg::t_dp_stat stat;

    mhpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mhpq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_value         (i_value),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_top_value     (o_top_value),
        .o_entry_count   (o_entry_count),
        .o_heap_empty    (o_heap_empty)
    );

    a_one_word_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("Input accepted again while an operation was in progress.");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_heap_empty == (o_entry_count == '0)))
        else $error("Empty flag disagrees with the entry count.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY)))
        else $error("Entry count exceeds the capacity.");

    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == mhpq_pkg::STATUS_EMPTY)) |->
        ((o_removed_value == '0) && (o_top_value == '0) && o_heap_empty))
        else $error("Remove on an empty heap reported data.");

endmodule
